// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication on the same edge, off during reset
`define PFV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication on the next edge, off during reset
`define PFV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pfv_pkg.sv
// Package for the polyline frame vectors unit: widths, constants, codes and
// the command and status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfv_pkg;

    localparam int PT_W       = 32;      // Q16.16 coordinate
    localparam int SEG_W      = 34;      // exact coordinate difference
    localparam int VQ_W       = 16;      // Q2.14 vector component
    localparam int IDX_W      = 14;      // point index
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_POINTS_DEF = 16384;
    localparam int IDX_MAX    = 16383;
    localparam int ONE_Q14    = 16384;
    localparam int QUO_W      = 15;      // quotient bits of one component

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 2'd2;

    typedef logic signed [VQ_W-1:0] vq_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store_first;   // hold the opening point of a line
        logic load_in;       // capture the incoming point
        logic set_single;    // zero tangent, index 0, final: lone point
        logic start_seg;     // normalise the current segment
        logic take_dir;      // latch direction, form the first or interior tangent
        logic set_end;       // tangent of the final point
        logic start_cross;   // normalise normal x tangent
        logic write_out;     // load the output word
        logic store_state;   // advance to the next point
        logic clear_line;    // close the polyline
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic held;
        logic cur_last;
        logic norm_done;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/pfv_if.sv
// Channel interfaces of the polyline frame vectors unit: point, result and
// configuration words with valid/ready. Depends on pfv_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pfv_point_if;
    logic                               valid;
    logic                               ready;
    logic signed [pfv_pkg::PT_W-1:0]    point_x;
    logic signed [pfv_pkg::PT_W-1:0]    point_y;
    logic signed [pfv_pkg::PT_W-1:0]    point_z;
    logic                               last_point;

    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface pfv_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [pfv_pkg::VQ_W-1:0]    tangent_x;
    logic signed [pfv_pkg::VQ_W-1:0]    tangent_y;
    logic signed [pfv_pkg::VQ_W-1:0]    tangent_z;
    logic signed [pfv_pkg::VQ_W-1:0]    propagation_x;
    logic signed [pfv_pkg::VQ_W-1:0]    propagation_y;
    logic signed [pfv_pkg::VQ_W-1:0]    propagation_z;
    logic [pfv_pkg::IDX_W-1:0]          point_index;
    logic                               final_result;
    logic                               degenerate;

    modport source (output valid, tangent_x, tangent_y, tangent_z, propagation_x,
                    propagation_y, propagation_z, point_index, final_result,
                    degenerate, input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, propagation_x,
                    propagation_y, propagation_z, point_index, final_result,
                    degenerate, output ready);
endinterface

interface pfv_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pfv_pkg::CFG_IDX_W-1:0]      reg_index;
    logic [pfv_pkg::VQ_W-1:0]           wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pfv_norm.sv
// Iterative vector normaliser: scale, sum of squares, bit-serial square root
// and three restoring divides to a Q2.14 unit vector. Depends on pfv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfv_norm (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [pfv_pkg::SEG_W-1:0]  vec_x,
    input  wire logic signed [pfv_pkg::SEG_W-1:0]  vec_y,
    input  wire logic signed [pfv_pkg::SEG_W-1:0]  vec_z,
    output logic                                   done,
    output logic                                   ok,
    output pfv_pkg::vq_t                           unit_x,
    output pfv_pkg::vq_t                           unit_y,
    output pfv_pkg::vq_t                           unit_z
);

    localparam int SW = pfv_pkg::SEG_W;
    localparam int DW = 47;   // dividend: magnitude * 2^14 plus half the length

    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_SHIFT = 6'b000010,
        N_SQ    = 6'b000100,
        N_SQRT  = 6'b001000,
        N_DLOAD = 6'b010000,
        N_DSTEP = 6'b100000
    } norm_state_t;

    norm_state_t          state_reg, state_next;
    logic [SW-1:0]        mag_reg [3];
    logic [SW-1:0]        mag_next [3];
    logic [2:0]           neg_reg, neg_next;
    logic [63:0]          sum_reg, sum_next;
    logic [63:0]          rad_reg, rad_next;
    logic [63:0]          root_reg, root_next;
    logic [63:0]          bit_reg, bit_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        dsr_reg, dsr_next;
    logic [pfv_pkg::QUO_W-1:0] quo_reg, quo_next, quo_clip;
    logic [1:0]           comp_reg, comp_next;
    logic [3:0]           step_reg, step_next;
    logic                 ok_reg, ok_next;
    logic                 done_reg, done_next;
    pfv_pkg::vq_t         unit_reg [3];
    pfv_pkg::vq_t         unit_next [3];

    logic signed [SW-1:0] vin [3];
    logic [SW-1:0]        mmax;
    logic [30:0]          msel;
    logic [61:0]          sq;
    logic [63:0]          trial;

    assign vin[0] = vec_x;
    assign vin[1] = vec_y;
    assign vin[2] = vec_z;

    // Largest magnitude, selected component, its square, root trial value
    always_comb
    begin
        mmax = mag_reg[0];
        if (mag_reg[1] > mmax)
        begin
            mmax = mag_reg[1];
        end
        if (mag_reg[2] > mmax)
        begin
            mmax = mag_reg[2];
        end
    end

    assign msel  = mag_reg[comp_reg][30:0];
    assign sq    = {31'd0, msel} * {31'd0, msel};
    assign trial = root_reg + bit_reg;

    // Sequencer of the shared unit
    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        sum_next   = sum_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        quo_next   = quo_reg;
        quo_clip   = quo_reg;
        comp_next  = comp_reg;
        step_next  = step_reg;
        ok_next    = ok_reg;
        done_next  = 1'b0;
        unit_next  = unit_reg;

        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = vin[i][SW-1];
                        mag_next[i] = vin[i][SW-1] ? SW'(-vin[i]) : SW'(vin[i]);
                    end
                    state_next = N_SHIFT;
                end
            end
            N_SHIFT:
            begin
                // Bring the largest magnitude into [2^30, 2^31), one bit a cycle
                if (mmax == '0)
                begin
                    ok_next    = 1'b0;
                    done_next  = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        unit_next[i] = '0;
                    end
                    state_next = N_IDLE;
                end
                else if (mmax[SW-1:30] == '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = {mag_reg[i][SW-2:0], 1'b0};
                    end
                end
                else if (mmax[SW-1:31] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = {1'b0, mag_reg[i][SW-1:1]};
                    end
                end
                else
                begin
                    sum_next   = '0;
                    comp_next  = 2'd0;
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                // Accumulate one square a cycle
                sum_next = sum_reg + {2'b00, sq};
                if (comp_reg == 2'd2)
                begin
                    rad_next   = sum_reg + {2'b00, sq};
                    root_next  = '0;
                    bit_next   = 64'd1 << 62;
                    state_next = N_SQRT;
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            N_SQRT:
            begin
                // One root bit a cycle
                if (rad_reg >= trial)
                begin
                    rad_next  = rad_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    comp_next  = 2'd0;
                    state_next = N_DLOAD;
                end
            end
            N_DLOAD:
            begin
                // Dividend with half the length added for rounding
                rem_next   = {2'b00, msel, 14'd0} + {15'd0, root_reg[32:1]};
                dsr_next   = {1'b0, root_reg[31:0], 14'd0};
                quo_next   = '0;
                step_next  = '0;
                state_next = N_DSTEP;
            end
            N_DSTEP:
            begin
                // One quotient bit a cycle
                if (rem_reg >= dsr_reg)
                begin
                    rem_next = rem_reg - dsr_reg;
                    quo_next = {quo_reg[pfv_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[pfv_pkg::QUO_W-2:0], 1'b0};
                end
                dsr_next  = dsr_reg >> 1;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(pfv_pkg::QUO_W - 1))
                begin
                    quo_clip = (quo_next > pfv_pkg::QUO_W'(pfv_pkg::ONE_Q14))
                             ? pfv_pkg::QUO_W'(pfv_pkg::ONE_Q14) : quo_next;
                    unit_next[comp_reg] = neg_reg[comp_reg]
                                        ? -$signed({1'b0, quo_clip})
                                        : $signed({1'b0, quo_clip});
                    if (comp_reg == 2'd2)
                    begin
                        ok_next    = 1'b1;
                        done_next  = 1'b1;
                        state_next = N_IDLE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = N_DLOAD;
                    end
                end
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        sum_reg  <= sum_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quo_reg  <= quo_next;
        comp_reg <= comp_next;
        step_reg <= step_next;
        ok_reg   <= ok_next;
        unit_reg <= unit_next;
    end

    assign done   = done_reg;
    assign ok     = ok_reg;
    assign unit_x = unit_reg[0];
    assign unit_y = unit_reg[1];
    assign unit_z = unit_reg[2];

endmodule

`default_nettype wire

// File: hw/rtl/pfv_dp.sv
// Datapath: normal registers, held point and direction, tangent forming,
// cross product and the output word. Depends on pfv_pkg and pfv_norm.
`timescale 1ns / 1ps
`default_nettype none

module pfv_dp #(
    parameter int MAX_POINTS = pfv_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire pfv_pkg::dp_cmd_t                     cmd,
    output pfv_pkg::dp_status_t                       status,
    input  wire logic signed [pfv_pkg::PT_W-1:0]      point_x,
    input  wire logic signed [pfv_pkg::PT_W-1:0]      point_y,
    input  wire logic signed [pfv_pkg::PT_W-1:0]      point_z,
    input  wire logic                                 last_point,
    input  wire logic                                 cfg_we,
    input  wire logic [pfv_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [pfv_pkg::VQ_W-1:0]             cfg_data,
    output pfv_pkg::vq_t                              tangent_x,
    output pfv_pkg::vq_t                              tangent_y,
    output pfv_pkg::vq_t                              tangent_z,
    output pfv_pkg::vq_t                              propagation_x,
    output pfv_pkg::vq_t                              propagation_y,
    output pfv_pkg::vq_t                              propagation_z,
    output logic [pfv_pkg::IDX_W-1:0]                 point_index,
    output logic                                      final_result,
    output logic                                      degenerate
);

    localparam int PW = pfv_pkg::PT_W;
    localparam int SW = pfv_pkg::SEG_W;
    localparam int IW = pfv_pkg::IDX_W;
    localparam int IDX_LIM = (MAX_POINTS - 1 < pfv_pkg::IDX_MAX)
                           ? MAX_POINTS - 1 : pfv_pkg::IDX_MAX;

    pfv_pkg::vq_t            nrm_reg [3];
    logic                    held_reg;
    logic [IW-1:0]           ps_reg;
    logic signed [PW-1:0]    cur_reg [3];
    logic                    cur_last_reg;
    logic signed [PW-1:0]    prev_reg [3];
    pfv_pkg::vq_t            pdir_reg [3];
    logic                    pbad_reg;
    pfv_pkg::vq_t            dir_reg [3];
    logic                    dir_ok_reg;
    pfv_pkg::vq_t            tan_reg [3];
    logic                    tan_ok_reg;
    logic [IW-1:0]           idx_reg;
    logic                    fin_reg;
    pfv_pkg::vq_t            otan_reg [3];
    pfv_pkg::vq_t            oprop_reg [3];
    logic [IW-1:0]           oidx_reg;
    logic                    ofin_reg;
    logic                    odeg_reg;

    logic signed [PW-1:0]    pin [3];
    logic [IW-1:0]           ps_inc;
    logic signed [SW-1:0]    seg [3];
    logic signed [SW-1:0]    crs [3];
    logic signed [SW-1:0]    nvec [3];
    logic signed [16:0]      tsum [3];
    logic signed [16:0]      thalf [3];
    pfv_pkg::vq_t            tmid [3];
    logic signed [31:0]      pa [3];
    logic signed [31:0]      pb [3];
    logic                    norm_start, norm_done, norm_ok;
    pfv_pkg::vq_t            nu [3];
    logic                    res_ok;

    assign pin[0] = point_x;
    assign pin[1] = point_y;
    assign pin[2] = point_z;

    assign ps_inc = (ps_reg < IW'(pfv_pkg::IDX_MAX)) ? ps_reg + 1'b1 : ps_reg;

    // Segment, interior tangent and cross product, per component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            seg[i]   = SW'(cur_reg[i]) - SW'(prev_reg[i]);
            tsum[i]  = 17'(nu[i]) + 17'(pdir_reg[i]);
            thalf[i] = tsum[i] + {16'd0, tsum[i][16]};
            tmid[i]  = thalf[i][16:1];
        end
        pa[0] = nrm_reg[1] * tan_reg[2];
        pb[0] = nrm_reg[2] * tan_reg[1];
        pa[1] = nrm_reg[2] * tan_reg[0];
        pb[1] = nrm_reg[0] * tan_reg[2];
        pa[2] = nrm_reg[0] * tan_reg[1];
        pb[2] = nrm_reg[1] * tan_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            crs[i]  = SW'(pa[i]) - SW'(pb[i]);
            nvec[i] = cmd.start_seg ? seg[i] : crs[i];
        end
    end

    assign norm_start = cmd.start_seg | cmd.start_cross;

    pfv_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .vec_x  (nvec[0]),
        .vec_y  (nvec[1]),
        .vec_z  (nvec[2]),
        .done   (norm_done),
        .ok     (norm_ok),
        .unit_x (nu[0]),
        .unit_y (nu[1]),
        .unit_z (nu[2])
    );

    // Normal registers and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrm_reg[0] <= '0;
            nrm_reg[1] <= '0;
            nrm_reg[2] <= pfv_pkg::VQ_W'(pfv_pkg::ONE_Q14);
            held_reg   <= 1'b0;
            ps_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pfv_pkg::CFG_NORMAL_X: nrm_reg[0] <= cfg_data;
                    pfv_pkg::CFG_NORMAL_Y: nrm_reg[1] <= cfg_data;
                    pfv_pkg::CFG_NORMAL_Z: nrm_reg[2] <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.store_first)
            begin
                held_reg <= 1'b1;
                ps_reg   <= '0;
            end
            else if (cmd.store_state)
            begin
                ps_reg <= ps_inc;
            end
            else if (cmd.clear_line)
            begin
                held_reg <= 1'b0;
                ps_reg   <= '0;
            end
        end
    end

    assign res_ok = tan_ok_reg & norm_ok;

    // Point, direction, tangent and output word
    always_ff @(posedge clk)
    begin
        if (cmd.store_first)
        begin
            prev_reg <= pin;
        end
        if (cmd.load_in)
        begin
            cur_reg      <= pin;
            cur_last_reg <= last_point;
        end
        if (cmd.set_single)
        begin
            cur_last_reg <= 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                tan_reg[i] <= '0;
            end
            tan_ok_reg <= 1'b0;
            idx_reg    <= '0;
            fin_reg    <= 1'b1;
        end
        if (cmd.take_dir)
        begin
            dir_reg    <= nu;
            dir_ok_reg <= norm_ok;
            idx_reg    <= ps_reg;
            fin_reg    <= 1'b0;
            if (ps_reg == '0)
            begin
                tan_reg    <= nu;
                tan_ok_reg <= norm_ok;
            end
            else
            begin
                tan_reg    <= tmid;
                tan_ok_reg <= norm_ok & ~pbad_reg;
            end
        end
        if (cmd.set_end)
        begin
            tan_reg    <= dir_reg;
            tan_ok_reg <= dir_ok_reg;
            idx_reg    <= ps_inc;
            fin_reg    <= 1'b1;
        end
        if (cmd.store_state)
        begin
            prev_reg <= cur_reg;
            pdir_reg <= dir_reg;
            pbad_reg <= ~dir_ok_reg;
        end
        if (cmd.write_out)
        begin
            for (int i = 0; i < 3; i++)
            begin
                otan_reg[i]  <= res_ok ? tan_reg[i] : '0;
                oprop_reg[i] <= res_ok ? nu[i] : '0;
            end
            oidx_reg <= (idx_reg > IW'(IDX_LIM)) ? IW'(IDX_LIM) : idx_reg;
            ofin_reg <= fin_reg;
            odeg_reg <= ~res_ok;
        end
    end

    assign status.held      = held_reg;
    assign status.cur_last  = cur_last_reg;
    assign status.norm_done = norm_done;

    assign tangent_x     = otan_reg[0];
    assign tangent_y     = otan_reg[1];
    assign tangent_z     = otan_reg[2];
    assign propagation_x = oprop_reg[0];
    assign propagation_y = oprop_reg[1];
    assign propagation_z = oprop_reg[2];
    assign point_index   = oidx_reg;
    assign final_result  = ofin_reg;
    assign degenerate    = odeg_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pfv_ctrl.sv
// Controller: sequences each point through segment and cross-product
// normalisation and hands out up to two result words. Depends on pfv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfv_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_last,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pfv_pkg::dp_cmd_t          cmd,
    input  wire pfv_pkg::dp_status_t  status
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SEG_GO   = 6'b000010,
        ST_SEG_WAIT = 6'b000100,
        ST_CRS_GO   = 6'b001000,
        ST_CRS_WAIT = 6'b010000,
        ST_OUT      = 6'b100000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        second_reg, second_next;
    logic        ovalid_reg, ovalid_next;
    logic        out_free;

    assign out_free = ~ovalid_reg | out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        ovalid_next = ovalid_reg & ~out_ready;
        cmd         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!status.held && in_last)
                    begin
                        // Lone point: one degenerate final word
                        cmd.set_single = 1'b1;
                        second_next    = 1'b1;
                        state_next     = ST_CRS_GO;
                    end
                    else if (!status.held)
                    begin
                        cmd.store_first = 1'b1;
                    end
                    else
                    begin
                        cmd.load_in = 1'b1;
                        second_next = 1'b0;
                        state_next  = ST_SEG_GO;
                    end
                end
            end
            ST_SEG_GO:
            begin
                cmd.start_seg = 1'b1;
                state_next    = ST_SEG_WAIT;
            end
            ST_SEG_WAIT:
            begin
                if (status.norm_done)
                begin
                    cmd.take_dir = 1'b1;
                    state_next   = ST_CRS_GO;
                end
            end
            ST_CRS_GO:
            begin
                cmd.start_cross = 1'b1;
                state_next      = ST_CRS_WAIT;
            end
            ST_CRS_WAIT:
            begin
                if (status.norm_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hand the word over once the output register is free
                if (out_free)
                begin
                    cmd.write_out = 1'b1;
                    ovalid_next   = 1'b1;
                    if (second_reg)
                    begin
                        cmd.clear_line = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (status.cur_last)
                    begin
                        cmd.set_end = 1'b1;
                        second_next = 1'b1;
                        state_next  = ST_CRS_GO;
                    end
                    else
                    begin
                        cmd.store_state = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/polyline_frame_vectors_unit.sv
// Top level of the polyline frame vectors unit: controller, datapath and
// channel ports. Depends on pfv_pkg, pfv_if, pfv_ctrl and pfv_dp.
//
//  channel     dir  words                           handshake
//  point_in    in   point_x/y/z, last_point         valid/ready
//  result_out  out  tangent, propagation, index...  valid/ready
//  cfg         in   reg_index, wdata                valid/ready (ready tied high)
//
// One point at a time. The shared normaliser scales, sums the squares, takes the root and
// does the three divides. A point runs it twice, a final point three times.
// Asynchronous active-low reset; normal resets to (0, 0, 1.0).
// A stalled result holds the controller in its output step; no point is
// taken until the previous point's words are in the output register.
`timescale 1ns / 1ps
`default_nettype none

module polyline_frame_vectors_unit #(
    parameter int MAX_POINTS = pfv_pkg::MAX_POINTS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pfv_cfg_if.sink      cfg,
    pfv_point_if.sink    point_in,
    pfv_result_if.source result_out
);

    pfv_pkg::dp_cmd_t    cmd;
    pfv_pkg::dp_status_t status;
    logic                in_ready;
    logic                out_valid;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    pfv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point_in.valid),
        .in_last   (point_in.last_point),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result_out.ready),
        .cmd       (cmd),
        .status    (status)
    );

    pfv_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .point_x       (point_in.point_x),
        .point_y       (point_in.point_y),
        .point_z       (point_in.point_z),
        .last_point    (point_in.last_point),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.reg_index),
        .cfg_data      (cfg.wdata),
        .tangent_x     (result_out.tangent_x),
        .tangent_y     (result_out.tangent_y),
        .tangent_z     (result_out.tangent_z),
        .propagation_x (result_out.propagation_x),
        .propagation_y (result_out.propagation_y),
        .propagation_z (result_out.propagation_z),
        .point_index   (result_out.point_index),
        .final_result  (result_out.final_result),
        .degenerate    (result_out.degenerate)
    );

    assign point_in.ready   = in_ready;
    assign result_out.valid = out_valid;

endmodule

`default_nettype wire

// File: hw/rtl/pfv_chk.sv
// Port checker for the polyline frame vectors unit, bound to the top level.
// Depends on pfv_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pfv_chk (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [pfv_pkg::VQ_W-1:0]    tangent_x,
    input wire logic [pfv_pkg::VQ_W-1:0]    tangent_y,
    input wire logic [pfv_pkg::VQ_W-1:0]    tangent_z,
    input wire logic [pfv_pkg::VQ_W-1:0]    propagation_x,
    input wire logic [pfv_pkg::VQ_W-1:0]    propagation_y,
    input wire logic [pfv_pkg::VQ_W-1:0]    propagation_z,
    input wire logic [pfv_pkg::IDX_W-1:0]   point_index,
    input wire logic                        final_result,
    input wire logic                        degenerate
);

    // A stalled result word stays offered
    `PFV_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid,
        "result word dropped while stalled")

    // Degenerate words carry zero vectors
    `PFV_ASSERT_IMP(a_deg_zero, out_valid && degenerate,
        tangent_x == '0 && tangent_y == '0 && tangent_z == '0 &&
        propagation_x == '0 && propagation_y == '0 && propagation_z == '0,
        "degenerate word with non-zero vectors")

    // A good word has a non-zero unit propagation vector
    `PFV_ASSERT_IMP(a_prop_nz, out_valid && !degenerate,
        propagation_x != '0 || propagation_y != '0 || propagation_z != '0,
        "good word with zero propagation vector")

    // A final word at index zero can only come from a lone point
    `PFV_ASSERT_IMP(a_single, out_valid && final_result && point_index == '0,
        degenerate, "lone point word not flagged degenerate")

endmodule

bind polyline_frame_vectors_unit pfv_chk u_pfv_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .tangent_x     (result_out.tangent_x),
    .tangent_y     (result_out.tangent_y),
    .tangent_z     (result_out.tangent_z),
    .propagation_x (result_out.propagation_x),
    .propagation_y (result_out.propagation_y),
    .propagation_z (result_out.propagation_z),
    .point_index   (result_out.point_index),
    .final_result  (result_out.final_result),
    .degenerate    (result_out.degenerate)
);

`default_nettype wire
